// ----- design/psq_pkg.sv -----
// Shared types and constants for the P-square multi-quantile estimator.
// Used by psq_arith and p_square_multi_quantile_unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psq_pkg;

  // Command codes on the input channel.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Operand and result width of the shared multiply/divide unit.
  localparam int XW = 64;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic          start;
    arith_op_t     op;
    logic [XW-1:0] a;
    logic [XW-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic          done;
    logic [XW-1:0] result;
  } arith_rsp_t;

endpackage

`default_nettype wire

// ----- design/psq_arith.sv -----
// Shared iterative arithmetic unit: saturating signed multiply and
// truncating signed divide, one bit per cycle. Depends on psq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psq_arith (
  input  wire                  clk,
  input  wire                  rst_n,
  input  psq_pkg::arith_req_t  req,
  output psq_pkg::arith_rsp_t  rsp
);

  localparam int XW = psq_pkg::XW;
  localparam int CW = $clog2(XW);

  logic                busy_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  psq_pkg::arith_op_t  op_r;
  logic                neg_r;
  logic                bz_r;
  logic [XW-1:0]       ub_r;
  logic [XW-1:0]       hi_r;
  logic [XW-1:0]       lo_r;

  logic [XW-1:0]       ua_in;
  logic [XW-1:0]       ub_in;
  logic [XW:0]         sum;
  logic [XW-1:0]       sh;
  logic [XW:0]         diff;
  logic [XW-1:0]       hi_nxt;
  logic [XW-1:0]       lo_nxt;
  logic [XW-1:0]       res;

  assign ua_in = req.a[XW-1] ? (XW'(0) - req.a) : req.a;
  assign ub_in = req.b[XW-1] ? (XW'(0) - req.b) : req.b;

  // Multiply shifts the product right through hi/lo; divide shifts the
  // dividend left out of lo into the remainder in hi.
  always_comb begin
    sum    = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ub_r} : '0);
    sh     = {hi_r[XW-2:0], lo_r[XW-1]};
    diff   = {1'b0, sh} - {1'b0, ub_r};
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    case (op_r)
      psq_pkg::OP_MUL: begin
        hi_nxt = sum[XW:1];
        lo_nxt = {sum[0], lo_r[XW-1:1]};
      end
      psq_pkg::OP_DIV: begin
        hi_nxt = diff[XW] ? sh : diff[XW-1:0];
        lo_nxt = {lo_r[XW-2:0], ~diff[XW]};
      end
      default: begin
        hi_nxt = hi_r;
        lo_nxt = lo_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(XW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      neg_r <= req.a[XW-1] ^ req.b[XW-1];
      bz_r  <= (req.b == '0);
      ub_r  <= ub_in;
      hi_r  <= '0;
      lo_r  <= ua_in;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  // Saturate the magnitude result and apply the sign.
  always_comb begin
    res = '0;
    case (op_r)
      psq_pkg::OP_MUL: begin
        if (neg_r) begin
          if (hi_r != '0 || (lo_r[XW-1] && lo_r[XW-2:0] != '0)) res = {1'b1, {(XW-1){1'b0}}};
          else res = XW'(0) - lo_r;
        end else begin
          if (hi_r != '0 || lo_r[XW-1]) res = {1'b0, {(XW-1){1'b1}}};
          else res = lo_r;
        end
      end
      psq_pkg::OP_DIV: begin
        if (bz_r) res = '0;
        else if (neg_r) res = XW'(0) - lo_r;
        else if (lo_r[XW-1]) res = {1'b0, {(XW-1){1'b1}}};
        else res = lo_r;
      end
      default: res = '0;
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.result = res;

endmodule

`default_nettype wire

// ----- design/p_square_multi_quantile_unit.sv -----
// Top level of the extended P-square multi-quantile estimator.
// Depends on psq_pkg and psq_arith.
//
// Usage: one input channel (in_valid/in_ready) carries a command, a sample
// and a marker index; one result channel (out_valid/out_ready) returns one
// result per input transfer: the requested marker height (zero for an add),
// the number of samples taken so far and the estimates-ready flag.
// The block handles one item at a time and is not ready while it works.
// A read fetches the requested marker height. For M markers, each of the
// first M-1 samples is stored directly; the sample that fills the last
// marker also runs an insertion sort over the marker memory. Later
// samples run the cell search, the position bumps and the marker walk,
// and each marker that moves runs three divisions and two multiplications
// on the single shared bit-serial arithmetic unit.
// Reset clears the sample count and the sequencer; marker memories need no
// clearing pass. A result waits in the output register while the receiver
// stalls, and the next input transfer is taken in the cycle the result goes.
`timescale 1ns / 1ps
`default_nettype none

module p_square_multi_quantile_unit #(
  parameter int QUANT_COUNT  = 19,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_command,
  input  wire  [31:0] in_sample,
  input  wire  [5:0]  in_marker_index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_height,
  output logic [31:0] out_sample_count,
  output logic        out_estimates_ready
);

  localparam int M     = 2 * QUANT_COUNT + 3;
  localparam int SCALE = M - 1;
  localparam int IW    = $clog2(M);
  localparam int HW    = SAMPLE_WIDTH;
  localparam int XW    = psq_pkg::XW;
  localparam int PW    = 33;
  localparam int KW    = 32 + IW;
  localparam int DDW   = 34 + IW;
  localparam logic [31:0] CNT_MAX = '1;

  typedef enum logic [24:0] {
    S_IDLE  = 25'h0000001,
    S_ADD   = 25'h0000002,
    S_RDA   = 25'h0000004,
    S_RDD   = 25'h0000008,
    S_FIN   = 25'h0000010,
    S_SRD   = 25'h0000020,
    S_SLD   = 25'h0000040,
    S_SCMP  = 25'h0000080,
    S_SPUT  = 25'h0000100,
    S_C0    = 25'h0000200,
    S_CLAST = 25'h0000400,
    S_CSCAN = 25'h0000800,
    S_BRD   = 25'h0001000,
    S_BWR   = 25'h0002000,
    S_AR0   = 25'h0004000,
    S_AR1   = 25'h0008000,
    S_AR2   = 25'h0010000,
    S_ADEC  = 25'h0020000,
    S_AQ1   = 25'h0040000,
    S_AQ2   = 25'h0080000,
    S_AQ3   = 25'h0100000,
    S_AGO   = 25'h0200000,
    S_AWAIT = 25'h0400000,
    S_AUPD  = 25'h0800000,
    S_SPARE = 25'h1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_HP = 3'd0,
    PH_HM = 3'd1,
    PH_M1 = 3'd2,
    PH_M2 = 3'd3,
    PH_DV = 3'd4
  } phase_t;

  function automatic logic signed [XW-1:0] sx(input logic [HW-1:0] v);
    sx = {{(XW-HW){v[HW-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] px(input logic [PW-1:0] v);
    px = {{(XW-PW){v[PW-1]}}, v};
  endfunction

  function automatic logic [XW-1:0] sat_add(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [XW-1:0] s;
    s = a + b;
    if (a[XW-1] == b[XW-1] && s[XW-1] != a[XW-1])
      sat_add = a[XW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
    else
      sat_add = s;
  endfunction

  function automatic logic [HW-1:0] conv(input logic [31:0] s);
    logic [HW-1:0] r;
    r = '0;
    for (int b = 0; b < HW; b++) begin
      if (b < 32) r[b] = s[b];
    end
    conv = r;
  endfunction

  // Memories
  logic [HW-1:0] q_mem [M];
  logic [31:0]   n_mem [M];
  logic [HW-1:0] q_rdata_r;
  logic [31:0]   n_rdata_r;
  logic          q_we, n_we;
  logic [IW-1:0] q_waddr, q_raddr, n_waddr, n_raddr;
  logic [HW-1:0] q_wdata;
  logic [31:0]   n_wdata;

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata_r <= q_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_we) n_mem[n_waddr] <= n_wdata;
    n_rdata_r <= n_mem[n_raddr];
  end

  // Shared arithmetic unit
  psq_pkg::arith_req_t areq;
  psq_pkg::arith_rsp_t arsp;

  psq_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  state_t          state_r, state_nxt;
  phase_t          ph_r, ph_nxt;
  logic [31:0]     cnt_r, cnt_nxt;
  logic [HW-1:0]   x_r, x_nxt;
  logic [5:0]      idx_r, idx_nxt;
  logic [31:0]     hold_r, hold_nxt;
  logic [IW-1:0]   i_r, i_nxt;
  logic [IW-1:0]   p_r, p_nxt;
  logic [HW-1:0]   v_r, v_nxt;
  logic [KW-1:0]   kc_r, kc_nxt;
  logic [31:0]     nm_r, nm_nxt;
  logic [31:0]     ni_r, ni_nxt;
  logic [PW-1:0]   dp_r, dp_nxt;
  logic [PW-1:0]   dm_r, dm_nxt;
  logic            up_r, up_nxt;
  logic [HW-1:0]   qm_r, qm_nxt;
  logic [HW-1:0]   qi_r, qi_nxt;
  logic [HW-1:0]   qp_r, qp_nxt;
  logic [XW-1:0]   hp_r, hp_nxt;
  logic [XW-1:0]   hm_r, hm_nxt;
  logic [XW-1:0]   t1_r, t1_nxt;
  logic [XW-1:0]   num_r, num_nxt;
  logic [XW-1:0]   step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_height_r, out_height_nxt;
  logic [31:0]     out_count_r, out_count_nxt;
  logic            out_rdy_r, out_rdy_nxt;

  logic            idx_ok;
  logic [XW-1:0]   qrd64;
  logic [PW-1:0]   dp_c, dm_c;
  logic [DDW-1:0]  dpos, spos, dd;
  logic            go_up, go_down;
  logic [XW-1:0]   s64, hcand, hnew;
  logic            last_marker;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign idx_ok   = ({1'b0, idx_r} < 7'(M));
  assign qrd64    = sx(q_rdata_r);

  // Marker offset test, in desired-position units scaled by M-1.
  assign dp_c  = {1'b0, n_rdata_r} - {1'b0, ni_r};
  assign dm_c  = {1'b0, nm_r} - {1'b0, ni_r};
  assign dpos  = DDW'(kc_r) + DDW'(SCALE) * (DDW'(i_r) + DDW'(1));
  assign spos  = DDW'(SCALE) * DDW'(ni_r);
  assign dd    = dpos - spos;
  assign go_up   = ($signed(dd) >= $signed(DDW'(SCALE))) && ($signed(dp_c) > $signed(PW'(1)));
  assign go_down = ($signed(dd) <= -$signed(DDW'(SCALE))) && ($signed(dm_c) < -$signed(PW'(1)));

  assign s64   = up_r ? XW'(1) : '1;
  assign hcand = sat_add(sx(qi_r), up_r ? step_r : (XW'(0) - step_r));
  assign hnew  = ($signed(sx(qm_r)) < $signed(hcand) && $signed(hcand) < $signed(sx(qp_r)))
                 ? hcand
                 : (up_r ? (sx(qi_r) + hp_r) : (sx(qi_r) - hm_r));
  assign last_marker = (i_r == IW'(M - 2));

  // Operands for the shared unit follow the update phase.
  always_comb begin
    areq.start = (state_r == S_AGO);
    areq.op    = psq_pkg::OP_DIV;
    areq.a     = '0;
    areq.b     = '0;
    case (ph_r)
      PH_HP: begin
        areq.a = sx(qp_r) - sx(qi_r);
        areq.b = px(dp_r);
      end
      PH_HM: begin
        areq.a = sx(qm_r) - sx(qi_r);
        areq.b = px(dm_r);
      end
      PH_M1: begin
        areq.op = psq_pkg::OP_MUL;
        areq.a  = s64 - px(dm_r);
        areq.b  = hp_r;
      end
      PH_M2: begin
        areq.op = psq_pkg::OP_MUL;
        areq.a  = px(dp_r) - s64;
        areq.b  = hm_r;
      end
      PH_DV: begin
        areq.a = num_r;
        areq.b = px(dp_r) - px(dm_r);
      end
      default: begin
        areq.a = '0;
        areq.b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    ph_nxt         = ph_r;
    cnt_nxt        = cnt_r;
    x_nxt          = x_r;
    idx_nxt        = idx_r;
    hold_nxt       = hold_r;
    i_nxt          = i_r;
    p_nxt          = p_r;
    v_nxt          = v_r;
    kc_nxt         = kc_r;
    nm_nxt         = nm_r;
    ni_nxt         = ni_r;
    dp_nxt         = dp_r;
    dm_nxt         = dm_r;
    up_nxt         = up_r;
    qm_nxt         = qm_r;
    qi_nxt         = qi_r;
    qp_nxt         = qp_r;
    hp_nxt         = hp_r;
    hm_nxt         = hm_r;
    t1_nxt         = t1_r;
    num_nxt        = num_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_height_nxt = out_height_r;
    out_count_nxt  = out_count_r;
    out_rdy_nxt    = out_rdy_r;
    q_we    = 1'b0;
    q_waddr = i_r;
    q_wdata = x_r;
    q_raddr = '0;
    n_we    = 1'b0;
    n_waddr = i_r;
    n_wdata = n_rdata_r + 32'd1;
    n_raddr = i_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          hold_nxt  = '0;
          idx_nxt   = in_marker_index;
          x_nxt     = conv(in_sample);
          state_nxt = (in_command == psq_pkg::CMD_READ) ? S_RDA : S_ADD;
        end
      end
      S_RDA: begin
        q_raddr   = idx_ok ? IW'(idx_r) : '0;
        state_nxt = S_RDD;
      end
      S_RDD: begin
        if (idx_ok) hold_nxt = qrd64[31:0];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        out_valid_nxt  = 1'b1;
        out_height_nxt = hold_r;
        out_count_nxt  = cnt_r;
        out_rdy_nxt    = (cnt_r >= 32'(M));
        state_nxt      = S_IDLE;
      end
      S_ADD: begin
        if (cnt_r < 32'(M)) begin
          // Warm-up: store the raw sample and its initial position.
          q_we    = 1'b1;
          q_waddr = IW'(cnt_r);
          q_wdata = x_r;
          n_we    = 1'b1;
          n_waddr = IW'(cnt_r);
          n_wdata = cnt_r + 32'd1;
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_r == 32'(M - 1)) begin
            i_nxt     = IW'(1);
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (cnt_r == CNT_MAX) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt   = cnt_r + 32'd1;
          q_raddr   = '0;
          state_nxt = S_C0;
        end
      end
      S_SRD: begin
        q_raddr   = i_r;
        state_nxt = S_SLD;
      end
      S_SLD: begin
        v_nxt     = q_rdata_r;
        p_nxt     = i_r;
        q_raddr   = i_r - IW'(1);
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        // q_rdata_r holds the marker just below the insertion point.
        if ($signed(q_rdata_r) > $signed(v_r)) begin
          q_we    = 1'b1;
          q_waddr = p_r;
          q_wdata = q_rdata_r;
          p_nxt   = p_r - IW'(1);
          if (p_r == IW'(1)) state_nxt = S_SPUT;
          else q_raddr = p_r - IW'(2);
        end else begin
          state_nxt = S_SPUT;
        end
      end
      S_SPUT: begin
        q_we    = 1'b1;
        q_waddr = p_r;
        q_wdata = v_r;
        if (i_r == IW'(M - 1)) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_SRD;
        end
      end
      S_C0: begin
        if ($signed(x_r) < $signed(q_rdata_r)) begin
          q_we      = 1'b1;
          q_waddr   = '0;
          i_nxt     = IW'(1);
          state_nxt = S_BRD;
        end else begin
          q_raddr   = IW'(M - 1);
          state_nxt = S_CLAST;
        end
      end
      S_CLAST: begin
        if ($signed(x_r) >= $signed(q_rdata_r)) begin
          q_we      = 1'b1;
          q_waddr   = IW'(M - 1);
          i_nxt     = IW'(M - 1);
          state_nxt = S_BRD;
        end else begin
          i_nxt     = IW'(1);
          q_raddr   = IW'(1);
          state_nxt = S_CSCAN;
        end
      end
      S_CSCAN: begin
        if ($signed(q_rdata_r) > $signed(x_r)) begin
          state_nxt = S_BRD;
        end else begin
          i_nxt   = i_r + IW'(1);
          q_raddr = i_r + IW'(1);
        end
      end
      S_BRD: begin
        n_raddr   = i_r;
        state_nxt = S_BWR;
      end
      S_BWR: begin
        n_we    = 1'b1;
        n_waddr = i_r;
        n_wdata = n_rdata_r + 32'd1;
        if (i_r == IW'(M - 1)) begin
          i_nxt     = IW'(1);
          state_nxt = S_AR0;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_BRD;
        end
      end
      S_AR0: begin
        n_raddr   = i_r - IW'(1);
        state_nxt = S_AR1;
      end
      S_AR1: begin
        nm_nxt    = n_rdata_r;
        n_raddr   = i_r;
        kc_nxt    = KW'(i_r) * KW'(cnt_r - 32'(M));
        state_nxt = S_AR2;
      end
      S_AR2: begin
        ni_nxt    = n_rdata_r;
        n_raddr   = i_r + IW'(1);
        state_nxt = S_ADEC;
      end
      S_ADEC: begin
        if (go_up || go_down) begin
          up_nxt    = go_up;
          dp_nxt    = dp_c;
          dm_nxt    = dm_c;
          q_raddr   = i_r - IW'(1);
          state_nxt = S_AQ1;
        end else if (last_marker) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_AR0;
        end
      end
      S_AQ1: begin
        qm_nxt    = q_rdata_r;
        q_raddr   = i_r;
        state_nxt = S_AQ2;
      end
      S_AQ2: begin
        qi_nxt    = q_rdata_r;
        q_raddr   = i_r + IW'(1);
        state_nxt = S_AQ3;
      end
      S_AQ3: begin
        qp_nxt    = q_rdata_r;
        ph_nxt    = PH_HP;
        state_nxt = S_AGO;
      end
      S_AGO: begin
        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (arsp.done) begin
          state_nxt = S_AGO;
          case (ph_r)
            PH_HP: begin
              hp_nxt = arsp.result;
              ph_nxt = PH_HM;
            end
            PH_HM: begin
              hm_nxt = arsp.result;
              ph_nxt = PH_M1;
            end
            PH_M1: begin
              t1_nxt = arsp.result;
              ph_nxt = PH_M2;
            end
            PH_M2: begin
              num_nxt = sat_add(t1_r, arsp.result);
              ph_nxt  = PH_DV;
            end
            PH_DV: begin
              step_nxt  = arsp.result;
              state_nxt = S_AUPD;
            end
            default: state_nxt = S_AUPD;
          endcase
        end
      end
      S_AUPD: begin
        // Parabolic candidate if it stays inside its neighbors, else linear.
        q_we    = 1'b1;
        q_waddr = i_r;
        q_wdata = hnew[HW-1:0];
        n_we    = 1'b1;
        n_waddr = i_r;
        n_wdata = up_r ? (ni_r + 32'd1) : (ni_r - 32'd1);
        if (last_marker) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_AR0;
        end
      end
      S_SPARE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      ph_r        <= PH_HP;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    idx_r        <= idx_nxt;
    hold_r       <= hold_nxt;
    i_r          <= i_nxt;
    p_r          <= p_nxt;
    v_r          <= v_nxt;
    kc_r         <= kc_nxt;
    nm_r         <= nm_nxt;
    ni_r         <= ni_nxt;
    dp_r         <= dp_nxt;
    dm_r         <= dm_nxt;
    up_r         <= up_nxt;
    qm_r         <= qm_nxt;
    qi_r         <= qi_nxt;
    qp_r         <= qp_nxt;
    hp_r         <= hp_nxt;
    hm_r         <= hm_nxt;
    t1_r         <= t1_nxt;
    num_r        <= num_nxt;
    step_r       <= step_nxt;
    out_height_r <= out_height_nxt;
    out_count_r  <= out_count_nxt;
    out_rdy_r    <= out_rdy_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_height          = out_height_r;
  assign out_sample_count    = out_count_r;
  assign out_estimates_ready = out_rdy_r;

endmodule

`default_nettype wire

// ----- tb/p_square_multi_quantile_unit_tb.sv -----
// Self-checking testbench for p_square_multi_quantile_unit: random and directed
// sample/read traffic with a built-in extended P-square predictor.
// Depends on psq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module p_square_multi_quantile_unit_tb;

  localparam int NQ = 19;
  localparam int NMARK = 2 * NQ + 3;
  localparam longint SCALE = NMARK - 1;
  localparam longint SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint SMIN = 64'h8000_0000_0000_0000;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [31:0] height;
    logic [31:0] count;
    logic        ready;
  } quantile_result_t;

  class quantile_scoreboard;
    longint heights[NMARK];
    int unsigned act_pos[NMARK];
    longint unsigned des_pos[NMARK];
    int unsigned seen;
    quantile_result_t pending[$];
    int errors;

    function new();
      for (int k = 0; k < NMARK; k++) begin
        heights[k] = 0;
        act_pos[k] = k + 1;
        des_pos[k] = SCALE * (k + 1);
      end
      seen = 0;
      errors = 0;
    endfunction

    function longint sat_add(longint a, longint b);
      logic signed [65:0] s;
      s = 66'(a) + 66'(b);
      if (s > 66'(SMAX)) return SMAX;
      if (s < 66'(SMIN)) return SMIN;
      return longint'(s);
    endfunction

    function longint sat_mul(longint a, longint b);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b);
      if (p > 128'(SMAX)) return SMAX;
      if (p < 128'(SMIN)) return SMIN;
      return longint'(p);
    endfunction

    function longint div_tz(longint a, longint b);
      if (b == 0) return 0;
      if (a == SMIN && b == -1) return SMAX;
      return a / b;
    endfunction

    function void sort_heights();
      longint v;
      int j;
      for (int i = 1; i < NMARK; i++) begin
        v = heights[i];
        j = i - 1;
        while (j >= 0 && heights[j] > v) begin
          heights[j + 1] = heights[j];
          j--;
        end
        heights[j + 1] = v;
      end
    endfunction

    function void move_marker(int i);
      longint dd, dp, dm, s, hp, hm, num, step, h;
      bit up, down;
      dd = longint'(des_pos[i]) - SCALE * longint'(act_pos[i]);
      dp = longint'(act_pos[i + 1]) - longint'(act_pos[i]);
      dm = longint'(act_pos[i - 1]) - longint'(act_pos[i]);
      up = dd >= SCALE && dp > 1;
      down = dd <= -SCALE && dm < -1;
      if (!up && !down) return;
      s = up ? 1 : -1;
      hp = div_tz(heights[i + 1] - heights[i], dp);
      hm = div_tz(heights[i - 1] - heights[i], dm);
      num = sat_add(sat_mul(s - dm, hp), sat_mul(dp - s, hm));
      step = div_tz(num, dp - dm);
      h = sat_add(heights[i], up ? step : -step);
      if (heights[i - 1] < h && h < heights[i + 1]) heights[i] = h;
      else if (up) heights[i] += hp;
      else heights[i] -= hm;
      if (up) act_pos[i]++;
      else act_pos[i]--;
    endfunction

    function void take_sample(longint x);
      int slot;
      if (seen < NMARK) begin
        heights[seen] = x;
        seen++;
        if (seen == NMARK) sort_heights();
        return;
      end
      if (seen == 32'hFFFF_FFFF) return;
      seen++;
      if (x < heights[0]) begin
        heights[0] = x;
        slot = 1;
      end else if (x >= heights[NMARK - 1]) begin
        heights[NMARK - 1] = x;
        slot = NMARK - 1;
      end else begin
        slot = NMARK - 1;
        for (int i = 1; i < NMARK; i++) begin
          if (heights[i] > x) begin
            slot = i;
            break;
          end
        end
      end
      for (int i = slot; i < NMARK; i++) act_pos[i]++;
      for (int i = 0; i < NMARK; i++) des_pos[i] += i;
      for (int i = 1; i <= NMARK - 2; i++) move_marker(i);
    endfunction

    // Called for every accepted input transfer.
    function void note_input(logic cmd, logic [31:0] smp, logic [5:0] idx);
      quantile_result_t r;
      r.height = '0;
      if (cmd == psq_pkg::CMD_ADD) take_sample(longint'($signed(smp)));
      else if (idx < NMARK) r.height = heights[idx][31:0];
      r.count = seen;
      r.ready = seen >= NMARK;
      pending = {pending, r};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] h, logic [31:0] c, logic r);
      quantile_result_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending", h, '0);
        return;
      end
      e = pending.pop_front();
      if (h !== e.height) report("height", h, e.height);
      if (c !== e.count) report("sample_count", c, e.count);
      if (r !== e.ready) report("estimates_ready", 32'(r), 32'(e.ready));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_command = psq_pkg::CMD_ADD;
  logic [31:0] in_sample = '0;
  logic [5:0]  in_marker_index = '0;
  logic        out_ready = 0;
  logic        in_ready, out_valid, out_estimates_ready;
  logic [31:0] out_height, out_sample_count;

  quantile_scoreboard sb = new();
  int  items_sent = 0;
  int  adds_sent = 0;
  bit  calm = 0;
  int  idle_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  p_square_multi_quantile_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_sample(in_sample),
    .in_marker_index(in_marker_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_height(out_height), .out_sample_count(out_sample_count),
    .out_estimates_ready(out_estimates_ready)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_command, in_sample, in_marker_index);
      if (out_valid && out_ready)
        sb.check_result(out_height, out_sample_count, out_estimates_ready);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("p_square_multi_quantile_unit: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the block backs up.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= 120) begin
        held = 1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  task send(logic cmd, logic [31:0] smp, logic [5:0] idx);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    in_command <= cmd;
    in_sample <= smp;
    in_marker_index <= idx;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (cmd == psq_pkg::CMD_ADD) adds_sent++;
  endtask

  task add(logic [31:0] smp);
    send(psq_pkg::CMD_ADD, smp, 6'($urandom));
  endtask

  // Reads never touch a marker that has not been written yet.
  task read_marker(logic [5:0] idx);
    if (adds_sent < NMARK && idx < NMARK && idx >= adds_sent) idx = 6'(NMARK);
    send(psq_pkg::CMD_READ, $urandom, idx);
  endtask

  function logic [31:0] pick_sample();
    int m;
    m = $urandom_range(9);
    if (m < 6) return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
    if (m < 9) return $urandom;
    return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: extremes, duplicates, reads before and after the fill.
    read_marker(6'd63);
    add(32'h8000_0000);
    add(32'h7FFF_FFFF);
    add(32'h0000_0000);
    add(32'hFFFF_FFFF);
    add(32'h7FFF_FFFF);
    read_marker(6'd0);
    read_marker(6'd4);
    read_marker(6'd41);
    while (adds_sent < NMARK) add(32'($signed($urandom_range(8 << 16)) - (4 << 16)));
    read_marker(6'd0);
    read_marker(6'd20);
    read_marker(6'd40);
    add(32'h8000_0000);
    add(32'h7FFF_FFFF);
    add(32'h7FFF_FFFF);
    read_marker(6'd40);

    for (int n = 0; n < 250; n++) begin
      calm = (n >= 150 && n < 210);
      if ($urandom_range(99) < 75) add(pick_sample());
      else read_marker(6'($urandom));
    end
    calm = 0;
    @(posedge clk);
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("p_square_multi_quantile_unit: match");
    else $display("p_square_multi_quantile_unit: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
design/psq_pkg.sv
design/psq_arith.sv
design/p_square_multi_quantile_unit.sv
tb/p_square_multi_quantile_unit_tb.sv
